[rtl/egsa_pkg.sv]
// ============================================================================
// egsa_pkg
// Shared constants, codes and types of the embedding gradient scatter-add core.
// ============================================================================
package egsa_pkg;

  localparam int unsigned MAX_ROWS    = 256;
  localparam int unsigned MAX_COLS    = 64;
  localparam int unsigned STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned TAG_W       = 4;
  localparam int unsigned WORD_W      = DATA_W + TAG_W;

  localparam int unsigned NUM_ROWS_W  = 9;
  localparam int unsigned ROW_WIDTH_W = 7;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 9;

  localparam logic [NUM_ROWS_W-1:0]  NUM_ROWS_RST  = NUM_ROWS_W'(256);
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = ROW_WIDTH_W'(64);

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = CFG_IDX_W'(1);

  localparam logic [1:0] OP_ACCUMULATE = 2'd0;
  localparam logic [1:0] OP_READ       = 2'd1;
  localparam logic [1:0] OP_CLEAR      = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ROW   = 2'd1;
  localparam logic [1:0] ST_BAD_COL   = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  // epoch tags: stale is what the sweep writes, live epochs run first..last
  localparam logic [TAG_W-1:0] EPOCH_STALE = TAG_W'(0);
  localparam logic [TAG_W-1:0] EPOCH_FIRST = TAG_W'(1);
  localparam logic [TAG_W-1:0] EPOCH_LAST  = {TAG_W{1'b1}};

  typedef struct packed {
    logic              access;   // accumulate or read on a good entry
    logic              acc;      // operation is accumulate
    logic              clear;    // operation is clear
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
  } egsa_dec_t;

endpackage

[rtl/egsa_ram.sv]
// ============================================================================
// egsa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module egsa_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/egsa_decode.sv]
// ============================================================================
// egsa_decode
// Operation decode, row and column range checks and table address.
// ============================================================================
module egsa_decode
  import egsa_pkg::*;
(
  input  logic [1:0]             operation_i,
  input  logic [31:0]            row_index_i,
  input  logic [5:0]             column_i,
  input  logic [NUM_ROWS_W-1:0]  num_rows_i,
  input  logic [ROW_WIDTH_W-1:0] row_width_i,
  output egsa_dec_t              dec_o
);

  logic [31:0] rows_cfg;
  logic [31:0] rows_lim;
  logic [31:0] cols_cfg;
  logic [31:0] cols_lim;
  logic        row_bad;
  logic        col_bad;
  logic        is_access_op;

  assign rows_cfg = 32'(num_rows_i);
  assign rows_lim = (rows_cfg < 32'(MAX_ROWS)) ? rows_cfg : 32'(MAX_ROWS);
  assign cols_cfg = 32'(row_width_i);
  assign cols_lim = (cols_cfg < 32'(MAX_COLS)) ? cols_cfg : 32'(MAX_COLS);

  assign row_bad = row_index_i[31] || (row_index_i >= rows_lim);
  assign col_bad = (32'(column_i) >= cols_lim);

  always_comb begin
    dec_o        = '0;
    is_access_op = 1'b0;
    case (operation_i)
      OP_ACCUMULATE: begin
        is_access_op = 1'b1;
        dec_o.acc    = 1'b1;
      end
      OP_READ: begin
        is_access_op = 1'b1;
      end
      OP_CLEAR: begin
        dec_o.clear = 1'b1;
      end
      default: begin
        is_access_op = 1'b0;
      end
    endcase
    dec_o.addr = ADDR_W'(row_index_i * 32'(MAX_COLS) + 32'(column_i));
    if (is_access_op) begin
      if (row_bad) begin
        dec_o.status = ST_BAD_ROW;
      end else if (col_bad) begin
        dec_o.status = ST_BAD_COL;
      end else begin
        dec_o.access = 1'b1;
      end
    end
  end

endmodule

[rtl/egsa_sat_add.sv]
// ============================================================================
// egsa_sat_add
// Signed Q16.16 adder with saturation to the 32-bit range.
// ============================================================================
module egsa_sat_add
  import egsa_pkg::*;
(
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  output logic [DATA_W-1:0] sum_o,
  output logic              sat_o
);

  logic [DATA_W:0] wide;

  assign wide  = {a_i[DATA_W-1], a_i} + {b_i[DATA_W-1], b_i};
  assign sat_o = wide[DATA_W] ^ wide[DATA_W-1];

  always_comb begin
    if (!sat_o) begin
      sum_o = wide[DATA_W-1:0];
    end else if (wide[DATA_W]) begin
      sum_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sum_o = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

[rtl/embedding_gradient_scatter_add_core.sv]
// ============================================================================
// embedding_gradient_scatter_add_core
// Gradient table accumulator: 256 x 64 Q16.16 entries in one RAM, each word
// tagged with a clear epoch; read-modify-write with same-entry forwarding.
// ============================================================================
//
//  channel   dir  beat fields
//  s_axis    in   tuser: operation | tdata: row_index, column, gradient_value
//  m_axis    out  tuser: status    | tdata: entry_value
//  cfg       in   cfg_index_i: register, cfg_data_i: value (0 num_rows, 1 row_width)
//
//  One beat a cycle while s_axis_tready is high; results pass the input stage and
//  result registers. s_axis_tready is low while a clear is in the input stage; the
//  epoch advances as it leaves. After reset and every fifteenth clear, all 16384
//  RAM tags are swept with s_axis_tready low. Config writes are taken at any time.
//  A stalled m_axis holds the result register and then the input stage.
//
module embedding_gradient_scatter_add_core
  import egsa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] row_index, [37:32] column, [69:38] gradient_value, [71:70] zero
  input  logic [71:0]           s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] entry_value
  output logic [31:0]           m_axis_tdata,
  // [1:0] status
  output logic [1:0]            m_axis_tuser,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [1:0] FSM_SWEEP = 2'd0;
  localparam logic [1:0] FSM_RUN   = 2'd1;
  localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(STORE_DEPTH - 1);

  logic [1:0]             state_q, state_d;
  logic [ADDR_W-1:0]      sweep_cnt_q, sweep_cnt_d;
  logic [TAG_W-1:0]       epoch_q, epoch_d;
  logic [NUM_ROWS_W-1:0]  num_rows_q;
  logic [ROW_WIDTH_W-1:0] row_width_q;

  logic                   s1_valid_q;
  egsa_dec_t              s1_dec_q;
  logic [DATA_W-1:0]      s1_grad_q;
  logic                   hit_q;
  logic [DATA_W-1:0]      fwd_data_q;

  logic                   out_valid_q;
  logic [DATA_W-1:0]      out_value_q;
  logic [1:0]             out_status_q;

  egsa_dec_t              in_dec;
  logic                   in_acc;
  logic                   s1_adv;
  logic                   acc_we;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [WORD_W-1:0]      mem_wdata;
  logic [WORD_W-1:0]      mem_rdata;
  logic [DATA_W-1:0]      cur_value;
  logic [DATA_W-1:0]      sum_value;
  logic                   sum_sat;
  logic [DATA_W-1:0]      res_value;
  logic [1:0]             res_status;

  egsa_decode u_decode (
    .operation_i (s_axis_tuser),
    .row_index_i (s_axis_tdata[31:0]),
    .column_i    (s_axis_tdata[37:32]),
    .num_rows_i  (num_rows_q),
    .row_width_i (row_width_q),
    .dec_o       (in_dec)
  );

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == FSM_RUN) && !(s1_valid_q && s1_dec_q.clear) &&
                         (!s1_valid_q || s1_adv);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign acc_we        = s1_adv && s1_dec_q.access && s1_dec_q.acc;

  always_comb begin
    if (state_q == FSM_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_cnt_q;
      mem_wdata = {EPOCH_STALE, {DATA_W{1'b0}}};
    end else begin
      mem_we    = acc_we;
      mem_waddr = s1_dec_q.addr;
      mem_wdata = {epoch_q, sum_value};
    end
  end

  egsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_acc),
    .raddr_i (in_dec.addr),
    .rdata_o (mem_rdata)
  );

  // entry written on the same edge as this read: take the written value
  always_comb begin
    if (hit_q) begin
      cur_value = fwd_data_q;
    end else if (mem_rdata[WORD_W-1:DATA_W] == epoch_q) begin
      cur_value = mem_rdata[DATA_W-1:0];
    end else begin
      cur_value = '0;
    end
  end

  egsa_sat_add u_sat_add (
    .a_i   (cur_value),
    .b_i   (s1_grad_q),
    .sum_o (sum_value),
    .sat_o (sum_sat)
  );

  always_comb begin
    res_value  = '0;
    res_status = s1_dec_q.status;
    if (s1_dec_q.access) begin
      if (s1_dec_q.acc) begin
        res_value  = sum_value;
        res_status = sum_sat ? ST_SATURATED : ST_OK;
      end else begin
        res_value  = cur_value;
        res_status = ST_OK;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    sweep_cnt_d = sweep_cnt_q;
    epoch_d     = epoch_q;
    case (state_q)
      FSM_SWEEP: begin
        sweep_cnt_d = sweep_cnt_q + ADDR_W'(1);
        if (sweep_cnt_q == SWEEP_LAST) begin
          state_d     = FSM_RUN;
          epoch_d     = EPOCH_FIRST;
          sweep_cnt_d = '0;
        end
      end
      FSM_RUN: begin
        if (s1_adv && s1_dec_q.clear) begin
          if (epoch_q == EPOCH_LAST) begin
            state_d = FSM_SWEEP;
          end else begin
            epoch_d = epoch_q + TAG_W'(1);
          end
        end
      end
      default: begin
        state_d     = FSM_SWEEP;
        sweep_cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_SWEEP;
      sweep_cnt_q <= '0;
      epoch_q     <= EPOCH_FIRST;
    end else begin
      state_q     <= state_d;
      sweep_cnt_q <= sweep_cnt_d;
      epoch_q     <= epoch_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q  <= NUM_ROWS_RST;
      row_width_q <= ROW_WIDTH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NUM_ROWS:  num_rows_q  <= cfg_data_i[NUM_ROWS_W-1:0];
        CFG_ROW_WIDTH: row_width_q <= cfg_data_i[ROW_WIDTH_W-1:0];
        default: begin
          num_rows_q <= num_rows_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_dec_q   <= in_dec;
      s1_grad_q  <= s_axis_tdata[69:38];
      hit_q      <= acc_we && (s1_dec_q.addr == in_dec.addr);
      fwd_data_q <= sum_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_value_q  <= res_value;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

endmodule
